/* rtl/torus_sequence_point_macros.svh */
// assertion macros shared by the checker
`ifndef TORUS_SEQUENCE_POINT_MACROS_SVH
`define TORUS_SEQUENCE_POINT_MACROS_SVH

// same-cycle implication under reset
`define TSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsp assertion failed");

// next-cycle implication under reset
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsp assertion failed");

`endif

/* rtl/tsp_pkg.sv */
// shared constants for the torus sequence point block
`timescale 1ns / 1ps
package tsp_pkg;

    localparam int FRAC_BITS_DEF  = 32;
    localparam int GUARD_BITS_DEF = 48;
    localparam int PRIME_BITS_DEF = 21;

    localparam int INDEX_W = 32;
    localparam int SUM_W   = INDEX_W + 1;
    localparam int COORD_W = 32;
    localparam int LIMB_W  = 32;

endpackage

/* rtl/tsp_if.sv */
// stream interfaces for sample beats and coordinate beats
`timescale 1ns / 1ps
interface tsp_in_if #(
    parameter int PRIME_BITS = tsp_pkg::PRIME_BITS_DEF
) ();
    import tsp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INDEX_W-1:0]    sample_index;
    logic [PRIME_BITS-1:0] prime_value;

    modport source (output valid, output sample_index, output prime_value, input ready);
    modport sink (input valid, input sample_index, input prime_value, output ready);
endinterface

interface tsp_out_if ();
    import tsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coordinate;

    modport source (output valid, output coordinate, input ready);
    modport sink (input valid, input coordinate, output ready);
endinterface

/* rtl/tsp_root_cell.sv */
// one digit step of the restoring square root, with index carried alongside
`timescale 1ns / 1ps
module tsp_root_cell #(
    parameter int RW = 59,
    parameter int P2 = 22
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [tsp_pkg::SUM_W-1:0] in_n,
    input  logic [P2-1:0]            in_rad,
    input  logic [RW:0]              in_rem,
    input  logic [RW-1:0]            in_root,
    output logic                     out_valid,
    output logic [tsp_pkg::SUM_W-1:0] out_n,
    output logic [P2-1:0]            out_rad,
    output logic [RW:0]              out_rem,
    output logic [RW-1:0]            out_root
);
    import tsp_pkg::*;

    logic              valid_reg;
    logic [SUM_W-1:0]  n_reg;
    logic [P2-1:0]     rad_reg;
    logic [RW:0]       rem_reg;
    logic [RW-1:0]     root_reg;

    logic [RW+2:0]     rem4;
    logic [RW+2:0]     trial;
    logic [RW+2:0]     diff;
    logic              ge;
    logic [RW:0]       rem_next;
    logic [RW-1:0]     root_next;
    logic [P2-1:0]     rad_next;

    always_comb
    begin
        rem4      = {in_rem, in_rad[P2-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        ge        = (rem4 >= trial);
        diff      = rem4 - trial;
        rem_next  = ge ? diff[RW:0] : rem4[RW:0];
        root_next = {in_root[RW-2:0], ge};
        rad_next  = in_rad << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= in_n;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

/* rtl/tsp_mul.sv */
// two-stage product of index and root fraction, top bits picked as coordinate
`timescale 1ns / 1ps
module tsp_mul #(
    parameter int GUARD_BITS = tsp_pkg::GUARD_BITS_DEF,
    parameter int FRAC_BITS  = tsp_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tsp_pkg::SUM_W-1:0]   in_n,
    input  logic [GUARD_BITS-1:0]       in_frac,
    output logic                        out_valid,
    output logic [tsp_pkg::COORD_W-1:0] out_coord
);
    import tsp_pkg::*;

    localparam int HW   = GUARD_BITS - LIMB_W;
    localparam int PW0  = SUM_W + LIMB_W;
    localparam int CW   = (FRAC_BITS < COORD_W) ? FRAC_BITS : COORD_W;
    localparam int EXTW = GUARD_BITS + FRAC_BITS;

    logic                  v1_reg;
    logic                  v2_reg;
    logic [GUARD_BITS-1:0] pp0_reg;
    logic [HW-1:0]         pp1_reg;
    logic [COORD_W-1:0]    coord_reg;

    logic [PW0-1:0]        prod0;
    logic [2*HW-1:0]       prod1;
    logic [GUARD_BITS-1:0] sum_frac;
    logic [EXTW-1:0]       ext;

    always_comb
    begin
        prod0    = {{LIMB_W{1'b0}}, in_n} * {{SUM_W{1'b0}}, in_frac[LIMB_W-1:0]};
        prod1    = {{HW{1'b0}}, in_n[HW-1:0]} * {{HW{1'b0}}, in_frac[GUARD_BITS-1:LIMB_W]};
        sum_frac = pp0_reg + {pp1_reg, {LIMB_W{1'b0}}};
        ext      = {sum_frac, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp0_reg   <= prod0[GUARD_BITS-1:0];
            pp1_reg   <= prod1[HW-1:0];
            coord_reg <= COORD_W'(ext[GUARD_BITS +: CW]);
        end
    end

    assign out_valid = v2_reg;
    assign out_coord = coord_reg;

endmodule

/* rtl/tsp_out_buf.sv */
// two-entry output buffer that decouples the pipeline from the sink
`timescale 1ns / 1ps
module tsp_out_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [tsp_pkg::COORD_W-1:0] push_data,
    output logic                        full,
    tsp_out_if.source                   point
);
    import tsp_pkg::*;

    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [COORD_W-1:0] entry_reg [2];
    logic               pop;

    assign pop              = point.valid && point.ready;
    assign full             = (count_reg == 2'd2);
    assign point.valid      = (count_reg != 2'd0);
    assign point.coordinate = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/torus_sequence_point.sv */
// top level of the torus sequence point generator
//
//   channel   dir   fields                          handshake
//   sample    in    sample_index, prime_value       valid/ready
//   point     out   coordinate                      valid/ready
//   cfg       in    cfg_wr_data (base index)        cfg_wr_en
//
// one beat per cycle sustained while the output buffer has room; the path runs through
// one root cell per root digit, then two multiply stages, then the output buffer
// input stalls only when the two-entry output buffer is full
// asynchronous active-low reset clears valid bits, buffer and base index
`timescale 1ns / 1ps
module torus_sequence_point #(
    parameter int FRAC_BITS  = tsp_pkg::FRAC_BITS_DEF,
    parameter int GUARD_BITS = tsp_pkg::GUARD_BITS_DEF,
    parameter int PRIME_BITS = tsp_pkg::PRIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [tsp_pkg::INDEX_W-1:0] cfg_wr_data,
    tsp_in_if.sink                      sample,
    tsp_out_if.source                   point
);
    import tsp_pkg::*;

    localparam int P2    = 2 * ((PRIME_BITS + 1) / 2);
    localparam int RW    = P2 / 2 + GUARD_BITS;
    localparam int NCELL = RW;

    logic [INDEX_W-1:0] base_reg;
    logic               en;
    logic               buf_full;
    logic               mul_valid;
    logic [COORD_W-1:0] mul_coord;

    logic               valid_w [NCELL+1];
    logic [SUM_W-1:0]   n_w     [NCELL+1];
    logic [P2-1:0]      rad_w   [NCELL+1];
    logic [RW:0]        rem_w   [NCELL+1];
    logic [RW-1:0]      root_w  [NCELL+1];

    assign en           = !buf_full;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    assign valid_w[0] = sample.valid;
    assign n_w[0]     = {1'b0, base_reg} + {1'b0, sample.sample_index};
    assign rad_w[0]   = P2'(sample.prime_value);
    assign rem_w[0]   = '0;
    assign root_w[0]  = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        tsp_root_cell #(
            .RW (RW),
            .P2 (P2)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_w[i]),
            .in_n      (n_w[i]),
            .in_rad    (rad_w[i]),
            .in_rem    (rem_w[i]),
            .in_root   (root_w[i]),
            .out_valid (valid_w[i+1]),
            .out_n     (n_w[i+1]),
            .out_rad   (rad_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_root  (root_w[i+1])
        );
    end

    tsp_mul #(
        .GUARD_BITS (GUARD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_w[NCELL]),
        .in_n      (n_w[NCELL]),
        .in_frac   (root_w[NCELL][GUARD_BITS-1:0]),
        .out_valid (mul_valid),
        .out_coord (mul_coord)
    );

    tsp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && mul_valid),
        .push_data (mul_coord),
        .full      (buf_full),
        .point     (point)
    );

endmodule

/* rtl/tsp_checker.sv */
// port-level assertions for the torus sequence point block
`timescale 1ns / 1ps
`include "torus_sequence_point_macros.svh"
module tsp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        sample_ready,
    input logic                        point_valid,
    input logic                        point_ready,
    input logic [tsp_pkg::COORD_W-1:0] coordinate
);
    import tsp_pkg::*;

    // input only backs up behind a waiting result
    `TSP_ASSERT_NOW(a_stall_has_result, clk, rst_n, !sample_ready, point_valid)

    // a taken result always leaves room for a new sample
    `TSP_ASSERT_NEXT(a_drain_frees_input, clk, rst_n, point_ready, sample_ready)

    `TSP_ASSERT_NEXT(a_point_valid_holds, clk, rst_n, point_valid && !point_ready, point_valid)

    `TSP_ASSERT_NEXT(a_point_data_holds, clk, rst_n, point_valid && !point_ready, $stable(coordinate))

endmodule

bind torus_sequence_point tsp_checker u_tsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .point_valid  (point.valid),
    .point_ready  (point.ready),
    .coordinate   (point.coordinate)
);

/* tb/sv/tb_torus_sequence_point.sv */
`timescale 1ns / 1ps
// self-checking testbench for the torus sequence point generator with stalls and base sweeps
module tb_torus_sequence_point;
    import tsp_pkg::*;

    localparam int PRIME_W = PRIME_BITS_DEF;
    localparam int GUARD_W = GUARD_BITS_DEF;
    localparam int FRAC_W  = FRAC_BITS_DEF;
    localparam int LATENCY = GUARD_W + 14 + 3;
    localparam int HOLD_LEN = 500;

    typedef struct packed {
        logic [INDEX_W-1:0] sample_index;
        logic [PRIME_W-1:0] prime_value;
    } sample_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [INDEX_W-1:0] cfg_wr_data;

    tsp_in_if #(.PRIME_BITS(PRIME_W)) sample_ch ();
    tsp_out_if point_ch ();

    torus_sequence_point u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch),
        .point       (point_ch)
    );

    sample_beat_t pending_samples[$];
    logic [COORD_W-1:0] expected_coords[$];
    logic [INDEX_W-1:0] base_copy = '0;
    int queued_count = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int in_idle_pct = 30;
    int out_idle_pct = 30;
    int hold_left = 0;
    int holds_done = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // fraction of n * sqrt(p), with sqrt(p) truncated to the guard bits, then to the coordinate width
    function automatic logic [COORD_W-1:0] torus_coord(input logic [SUM_W-1:0] n,
                                                       input logic [PRIME_W-1:0] p);
        logic [127:0] radicand;
        logic [127:0] root;
        logic [127:0] trial;
        logic [GUARD_W-1:0] root_frac;
        logic [SUM_W+GUARD_W-1:0] prod;
        int b;
        radicand = 128'(p) << (2 * GUARD_W);
        root = '0;
        for (b = 63; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        root_frac = root[GUARD_W-1:0];
        prod = n * root_frac;
        return prod[GUARD_W-1 -: FRAC_W];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // sample driver
    always @(posedge clk)
    begin : sample_driver
        sample_beat_t next_beat;
        logic taken;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else
        begin
            taken = sample_ch.valid && sample_ch.ready;
            if (taken)
            begin
                expected_coords.push_back(torus_coord(SUM_W'(base_copy)
                    + SUM_W'(sample_ch.sample_index), sample_ch.prime_value));
                accepted_count++;
            end
            if (!sample_ch.valid || taken)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    next_beat = pending_samples.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.sample_index <= next_beat.sample_index;
                    sample_ch.prime_value  <= next_beat.prime_value;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && accepted_count >= 400 + holds_done * 900)
        begin
            hold_left  <= HOLD_LEN;
            holds_done <= holds_done + 1;
        end
    end

    // point monitor
    always @(posedge clk)
    begin : point_monitor
        logic [COORD_W-1:0] want;
        if (!rst_n)
        begin
            point_ch.ready <= 1'b0;
        end
        else
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                if (expected_coords.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected coordinate %h", point_ch.coordinate));
                end
                else
                begin
                    want = expected_coords.pop_front();
                    if (point_ch.coordinate !== want)
                        report_mismatch($sformatf("coordinate %h, want %h",
                            point_ch.coordinate, want));
                end
            end
            point_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic queue_beat(input logic [INDEX_W-1:0] idx, input logic [PRIME_W-1:0] p);
        sample_beat_t beat;
        beat.sample_index = idx;
        beat.prime_value  = p;
        pending_samples.push_back(beat);
        queued_count++;
    endtask

    task automatic queue_random(input int count);
        logic [INDEX_W-1:0] idx;
        logic [PRIME_W-1:0] p;
        int k;
        int i;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: idx = '0;
                1: idx = '1;
                2: idx = INDEX_W'($urandom_range(255));
                3: idx = '1 - INDEX_W'($urandom_range(255));
                default: idx = $urandom;
            endcase
            case ($urandom_range(9))
                0: p = PRIME_W'($urandom_range(1));
                1:
                begin
                    k = $urandom_range(1448);
                    p = PRIME_W'(k * k);
                end
                2: p = PRIME_W'($urandom_range(2097151, 2097000));
                3, 4: p = PRIME_W'($urandom_range(63));
                default: p = PRIME_W'($urandom_range(2097151));
            endcase
            queue_beat(idx, p);
        end
    endtask

    task automatic drain;
        while (accepted_count != queued_count || expected_coords.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [INDEX_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        base_copy = value;
    endtask

    initial
    begin
        sample_ch.valid        = 1'b0;
        sample_ch.sample_index = '0;
        sample_ch.prime_value  = '0;
        point_ch.ready         = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        rst_n                  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base at its reset value: prime zero and one, squares, extremes
        queue_beat('0, '0);
        queue_beat(32'd1, '0);
        queue_beat(32'd5, 21'd1);
        queue_beat(32'd1, 21'd2);
        queue_beat(32'd7, 21'd3);
        queue_beat(32'd9, 21'd4);
        queue_beat(32'd123, 21'd1048576);
        queue_beat('1, 21'd2096704);
        queue_beat('1, '1);
        queue_beat(32'h8000_0000, 21'd15);
        queue_beat(32'h5555_5555, 21'h0A_AAAA);
        queue_beat(32'hAAAA_AAAA, 21'h15_5555);
        drain();

        // top base, index sum past 32 bits
        write_base('1);
        queue_beat('1, 21'd2);
        queue_beat('1, '1);
        queue_beat(32'd1, 21'd3);
        queue_beat('0, 21'd2097143);
        queue_beat(32'h8000_0000, 21'd1);
        queue_beat(32'hFFFF_FFFE, 21'd4);
        queue_beat(32'h0000_FFFF, 21'd999983);
        drain();

        write_base($urandom);
        queue_random(400);
        drain();

        write_base('0);
        queue_random(400);
        drain();

        // no idling on either side
        write_base('1);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        queue_random(400);
        drain();
        in_idle_pct  = 30;
        out_idle_pct = 30;

        write_base($urandom);
        queue_random(400);
        drain();

        write_base(32'd1);
        queue_random(400);
        drain();

        repeat (LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
